/* hw/rtl/bde_pkg.sv */
package bde_pkg;

  // ring store geometry
  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LEN_W   = 6;

  // stream packing
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 8;

  // compare width for count against length
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_DELETE     = 3'd5,
    MODE_READ_FIRST = 3'd6,
    MODE_READ_LAST  = 3'd7
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // physical slot of logical position pos, wraps once
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* hw/rtl/bounded_deque_engine.sv */
// push, pop and clear: the result is registered in the cycle after the request; next request
//   is taken as soon as the result register is free
// delete: one entry per cycle through the store read pipeline
// read first / last: each word out passes the store read, then the result register
// reset clears head, length and control; store contents stay undefined, no clear pass
module bounded_deque_engine
  import bde_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // value[31:0], count[37:32]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,  // mode[2:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // word_out[31:0], length_now[37:32]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,  // has_word[0], status[2:1]
  output logic                  m_axis_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL,
    S_DEL_FIN,
    S_RD_ISSUE,
    S_RD_DATA
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] end_q, end_d;
  logic [CNT_W-1:0] wpos_q, wpos_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic             rvalid_q, rvalid_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic              out_has_q, out_has_d;
  logic              out_last_q, out_last_d;
  status_e           out_stat_q, out_stat_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;

  // store
  logic [WORD_W-1:0] entry_mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  // request fields
  mode_e              in_mode;
  logic [WORD_W-1:0]  in_value;
  logic [COUNT_W-1:0] in_count;
  logic               in_fire;
  logic               out_free;

  logic [CMP_W-1:0] cnt_x, len_x, n_x;
  logic [CNT_W-1:0] n_c;

  assign in_mode  = mode_e'(s_axis_tuser_i[MODE_W-1:0]);
  assign in_value = s_axis_tdata_i[WORD_W-1:0];
  assign in_count = s_axis_tdata_i[WORD_W+COUNT_W-1:WORD_W];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // clamped read count
  assign cnt_x = CMP_W'(in_count);
  assign len_x = CMP_W'(len_q);
  assign n_x   = (cnt_x < len_x) ? cnt_x : len_x;
  assign n_c   = CNT_W'(n_x);

  // sequencer and result register next state
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    len_d       = len_q;
    pos_d       = pos_q;
    end_d       = end_q;
    wpos_d      = wpos_q;
    val_d       = val_q;
    rvalid_d    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_word_d  = out_word_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    out_stat_d  = out_stat_q;
    out_len_d   = out_len_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = slot(head_q, len_q);
    mem_raddr   = slot(head_q, pos_q);
    mem_wdata   = in_value;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // default: single status result
          out_valid_d = 1'b1;
          out_word_d  = '0;
          out_has_d   = 1'b0;
          out_last_d  = 1'b1;
          out_stat_d  = STAT_OK;
          case (in_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (len_q == CNT_W'(DEPTH)) begin
                out_stat_d = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                if (in_mode == MODE_PUSH_FRONT) begin
                  head_d    = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
                  mem_waddr = head_d;
                end
                len_d = len_q + 1'b1;
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (len_q == '0) begin
                out_stat_d = STAT_EMPTY;
              end else begin
                if (in_mode == MODE_POP_FRONT) begin
                  head_d = slot(head_q, CNT_W'(1));
                end
                len_d = len_q - 1'b1;
              end
            end
            MODE_CLEAR: begin
              head_d = '0;
              len_d  = '0;
            end
            MODE_DELETE: begin
              out_valid_d = out_valid_q && !m_axis_tready_i;
              val_d       = in_value;
              pos_d       = '0;
              wpos_d      = '0;
              state_d     = S_DEL;
            end
            default: begin
              // read first / read last
              if (len_q == '0) begin
                out_stat_d = STAT_EMPTY;
              end else if (n_c != '0) begin
                out_valid_d = out_valid_q && !m_axis_tready_i;
                pos_d       = (in_mode == MODE_READ_FIRST) ? '0 : len_q - n_c;
                end_d       = (in_mode == MODE_READ_FIRST) ? n_c : len_q;
                state_d     = S_RD_ISSUE;
              end
            end
          endcase
          out_len_d = LEN_W'(len_d);
        end
      end

      S_DEL: begin
        // read ahead one entry a cycle
        if (pos_q < len_q) begin
          mem_re   = 1'b1;
          rvalid_d = 1'b1;
          pos_d    = pos_q + 1'b1;
        end
        // compact kept words behind the read pointer
        if (rvalid_q && (rdata_q != val_q)) begin
          mem_we    = 1'b1;
          mem_waddr = slot(head_q, wpos_q);
          mem_wdata = rdata_q;
          wpos_d    = wpos_q + 1'b1;
        end
        if (!(pos_q < len_q) && !rvalid_q) begin
          len_d   = wpos_q;
          state_d = S_DEL_FIN;
        end
      end

      S_DEL_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '0;
          out_has_d   = 1'b0;
          out_last_d  = 1'b1;
          out_stat_d  = STAT_OK;
          out_len_d   = LEN_W'(len_q);
          state_d     = S_IDLE;
        end
      end

      S_RD_ISSUE: begin
        mem_re  = 1'b1;
        pos_d   = pos_q + 1'b1;
        state_d = S_RD_DATA;
      end

      S_RD_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = rdata_q;
          out_has_d   = 1'b1;
          out_last_d  = (pos_q == end_q);
          out_stat_d  = STAT_OK;
          out_len_d   = LEN_W'(len_q);
          state_d     = (pos_q == end_q) ? S_IDLE : S_RD_ISSUE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      end_q       <= '0;
      wpos_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      end_q       <= end_d;
      wpos_q      <= wpos_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_word_q <= out_word_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_stat_q <= out_stat_d;
    out_len_q  <= out_len_d;
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= entry_mem_q[mem_raddr];
    end
  end

  // output packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - WORD_W - LEN_W)'(0), out_len_q, out_word_q};
  assign m_axis_tuser_o  = {(OUT_USER_W - STAT_W - 1)'(0), out_stat_q, out_has_q};

endmodule
